FILE: rtl/core/abtu_pkg.sv
// Package for the AIMD bitrate target update block.
// Holds usage and register index codes, reset constants and the config struct.
// No dependencies.
package abtu_pkg;

  // Bandwidth usage codes carried on the usage field
  typedef enum logic [1:0] {
    USAGE_NORMAL = 2'd0,
    USAGE_OVER   = 2'd1,
    USAGE_UNDER  = 2'd2
  } usage_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MAX_BITRATE     = 3'd0,
    REG_DECREASE        = 3'd1,
    REG_STRONG_DECREASE = 3'd2,
    REG_INCREASE        = 3'd3,
    REG_HOLD_COUNT      = 3'd4,
    REG_ADDITIVE_STEP   = 3'd5,
    REG_UNDERUSE_BONUS  = 3'd6
  } cfg_reg_e;

  localparam int unsigned RateW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RunW    = 8;
  // Widest intermediate: Q16 product of 32x18 shifted, plus a 16-bit bonus
  localparam int unsigned NextW   = 35;

  localparam logic [RunW-1:0] RunMax = 8'd255;

  // Reset values
  localparam logic [31:0] MaxBitrateRst     = 32'd3000000;
  localparam logic [16:0] DecreaseRst       = 17'd55706;
  localparam logic [16:0] StrongDecreaseRst = 17'd52429;
  localparam logic [17:0] IncreaseRst       = 18'd68813;
  localparam logic [7:0]  HoldCountRst      = 8'd10;
  localparam logic [15:0] AdditiveStepRst   = 16'd100;
  localparam logic [15:0] UnderuseBonusRst  = 16'd1000;
  localparam logic [31:0] TargetRst         = 32'd1000000;
  localparam logic [31:0] FloorRst          = 32'd150000;

  // Current configuration as seen by the update logic
  typedef struct packed {
    logic [31:0] max_bitrate;
    logic [16:0] decrease_q16;
    logic [16:0] strong_decrease_q16;
    logic [17:0] increase_q16;
    logic [7:0]  hold_count;
    logic [15:0] additive_step;
    logic [15:0] underuse_bonus;
  } cfg_t;

endpackage

FILE: rtl/core/abtu_cfg_regs.sv
// Configuration register file for the AIMD bitrate target update block.
// Depends on abtu_pkg.
module abtu_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [abtu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  output abtu_pkg::cfg_t                cfg_o
);

  abtu_pkg::cfg_t cfg_q, cfg_d;

  // Decode a write request; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        abtu_pkg::REG_MAX_BITRATE:     cfg_d.max_bitrate         = cfg_data_i;
        abtu_pkg::REG_DECREASE:        cfg_d.decrease_q16        = cfg_data_i[16:0];
        abtu_pkg::REG_STRONG_DECREASE: cfg_d.strong_decrease_q16 = cfg_data_i[16:0];
        abtu_pkg::REG_INCREASE:        cfg_d.increase_q16        = cfg_data_i[17:0];
        abtu_pkg::REG_HOLD_COUNT:      cfg_d.hold_count          = cfg_data_i[7:0];
        abtu_pkg::REG_ADDITIVE_STEP:   cfg_d.additive_step       = cfg_data_i[15:0];
        abtu_pkg::REG_UNDERUSE_BONUS:  cfg_d.underuse_bonus      = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_bitrate         <= abtu_pkg::MaxBitrateRst;
      cfg_q.decrease_q16        <= abtu_pkg::DecreaseRst;
      cfg_q.strong_decrease_q16 <= abtu_pkg::StrongDecreaseRst;
      cfg_q.increase_q16        <= abtu_pkg::IncreaseRst;
      cfg_q.hold_count          <= abtu_pkg::HoldCountRst;
      cfg_q.additive_step       <= abtu_pkg::AdditiveStepRst;
      cfg_q.underuse_bonus      <= abtu_pkg::UnderuseBonusRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/abtu_update.sv
// Target update datapath and controller state (target, floor, last usage, run).
// One Q16 multiply, then add, clamp to max and floor. Depends on abtu_pkg.
module abtu_update (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic [abtu_pkg::RateW-1:0]   rate_i,
  input  logic [1:0]                   usage_i,
  input  abtu_pkg::cfg_t               cfg_i,
  output logic [abtu_pkg::RateW-1:0]   target_o,
  output logic                         changed_o
);

  logic [31:0]                 target_q, target_d;
  logic [31:0]                 floor_q, floor_d;
  abtu_pkg::usage_e            last_q, last_d;
  logic [abtu_pkg::RunW-1:0]   run_q, run_d;

  abtu_pkg::usage_e            usage;
  logic [31:0]                 lo, hi;
  logic [31:0]                 mul_a;
  logic [17:0]                 mul_b;
  logic [49:0]                 prod;
  logic [abtu_pkg::NextW-1:0]  next;
  logic [31:0]                 clamped;
  logic                        changed;

  // Code three is treated as underuse
  always_comb begin
    unique case (usage_i)
      abtu_pkg::USAGE_NORMAL: usage = abtu_pkg::USAGE_NORMAL;
      abtu_pkg::USAGE_OVER:   usage = abtu_pkg::USAGE_OVER;
      default:                usage = abtu_pkg::USAGE_UNDER;
    endcase
  end

  assign lo = (target_q > rate_i) ? rate_i : target_q;
  assign hi = (target_q < rate_i) ? rate_i : target_q;

  // Shared Q16 multiplier: cut on the smaller rate, raise on the larger
  always_comb begin
    if (usage == abtu_pkg::USAGE_OVER) begin
      mul_a = lo;
      mul_b = (last_q == abtu_pkg::USAGE_OVER) ? {1'b0, cfg_i.strong_decrease_q16}
                                               : {1'b0, cfg_i.decrease_q16};
    end else begin
      mul_a = hi;
      mul_b = cfg_i.increase_q16;
    end
  end

  assign prod = {18'd0, mul_a} * {32'd0, mul_b};

  // Next-state selection per usage transition
  always_comb begin
    next    = {3'd0, target_q};
    floor_d = floor_q;
    run_d   = '0;
    changed = 1'b0;
    unique case (usage)
      abtu_pkg::USAGE_NORMAL: begin
        priority if (last_q == abtu_pkg::USAGE_OVER) begin
          floor_d = target_q;
        end else if (last_q == abtu_pkg::USAGE_UNDER) begin
          floor_d = lo;
        end else begin
          if (run_q > cfg_i.hold_count) begin
            next    = {3'd0, hi} + {19'd0, cfg_i.additive_step};
            changed = 1'b1;
          end
          run_d = (run_q < abtu_pkg::RunMax) ? run_q + 8'd1 : run_q;
        end
      end
      abtu_pkg::USAGE_OVER: begin
        next    = {1'b0, prod[49:16]};
        changed = 1'b1;
      end
      default: begin
        next = {1'b0, prod[49:16]};
        if (last_q == abtu_pkg::USAGE_UNDER) begin
          next = {1'b0, prod[49:16]} + {19'd0, cfg_i.underuse_bonus};
        end
        changed = (last_q != abtu_pkg::USAGE_NORMAL);
      end
    endcase
  end

  // Clamp to the maximum first, then the (updated) floor wins
  always_comb begin
    clamped  = (next > {3'd0, cfg_i.max_bitrate}) ? cfg_i.max_bitrate : next[31:0];
    target_d = (clamped < floor_d) ? floor_d : clamped;
    last_d   = usage;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= abtu_pkg::TargetRst;
      floor_q  <= abtu_pkg::FloorRst;
      last_q   <= abtu_pkg::USAGE_NORMAL;
      run_q    <= '0;
    end else if (step_i) begin
      target_q <= target_d;
      floor_q  <= floor_d;
      last_q   <= last_d;
      run_q    <= run_d;
    end
  end

  assign target_o  = target_d;
  assign changed_o = changed;

endmodule

FILE: rtl/core/aimd_bitrate_target_update.sv
// Top level of the AIMD bitrate target update block: input register, update
// datapath, result register. Depends on abtu_pkg, abtu_cfg_regs, abtu_update.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_ready_o  rate_i, usage_i
//   out      source     out_valid_o/ out_ready_i target_bitrate_o, changed_o
//   cfg      sink       cfg_valid_i/ cfg_ready_o cfg_index_i, cfg_data_i
//
// A request sits in the input register after the edge that accepts it and is
// loaded into the result register at the next edge when that register is free,
// so its result is valid once it is in the result register; one request is
// taken every cycle while results are drained. The loop through the target
// register (multiply, add, clamp) sets the cycle time.
// Reset is asynchronous, active low, and restores the state, configuration and
// valid registers at once; payload registers are not reset.
// A stalled output holds its result; the input register still takes one more
// request, then in_ready_o drops until the result is taken.
module aimd_bitrate_target_update (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [abtu_pkg::RateW-1:0]   rate_i,
  input  logic [1:0]                   usage_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [abtu_pkg::RateW-1:0]   target_bitrate_o,
  output logic                         changed_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [abtu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);

  abtu_pkg::cfg_t cfg;

  logic                        in_vld_q;
  logic [abtu_pkg::RateW-1:0]  rate_q;
  logic [1:0]                  usage_q;
  logic                        out_vld_q;
  logic [abtu_pkg::RateW-1:0]  target_q;
  logic                        changed_q;
  logic [abtu_pkg::RateW-1:0]  target_nxt;
  logic                        changed_nxt;
  logic                        advance;

  assign cfg_ready_o = 1'b1;

  abtu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Request moves to the result register when that register is free or drains
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rate_q  <= rate_i;
      usage_q <= usage_i;
    end
  end

  abtu_update u_update (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rate_i    (rate_q),
    .usage_i   (usage_q),
    .cfg_i     (cfg),
    .target_o  (target_nxt),
    .changed_o (changed_nxt)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      target_q  <= target_nxt;
      changed_q <= changed_nxt;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign target_bitrate_o = target_q;
  assign changed_o        = changed_q;

endmodule

FILE: rtl/core/abtu_checker.sv
// Port-level checker for aimd_bitrate_target_update, bound to the top level.
// Depends on abtu_pkg.
module abtu_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_o,
  input  logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic [abtu_pkg::RateW-1:0]   target_bitrate_o,
  input  logic                         changed_o
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Requests taken but whose results are not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(target_bitrate_o)
      && $stable(changed_o))
    else $error("result changed while stalled");

  // No result without a request in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result without pending request");

  // At most two requests in flight (input and result registers)
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many requests in flight");

  // With both stages full and output stalled, no new request is taken
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 && !out_ready_i |-> !in_ready_o)
    else $error("request taken while full");

  // An empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

endmodule

bind aimd_bitrate_target_update abtu_checker u_abtu_checker (.*);
